// File: hdl/assert_macros.svh
// Assertion macros used by text_console_line_editor.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TCLE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define TCLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcle_pkg.sv
// Package for the text console line editor: sequencer states, copy modes,
// command codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps

package tcle_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ROWFIND,
    ST_COPY,
    ST_DRAIN,
    ST_PUT,
    ST_BLANK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CP_SCROLL,
    CP_INSERT,
    CP_LEFT
  } copy_mode_t;

  localparam logic [3:0] KIND_PUT       = 4'd0;
  localparam logic [3:0] KIND_BACKSPACE = 4'd1;
  localparam logic [3:0] KIND_DELETE    = 4'd2;
  localparam logic [3:0] KIND_LEFT      = 4'd3;
  localparam logic [3:0] KIND_RIGHT     = 4'd4;
  localparam logic [3:0] KIND_HOME      = 4'd5;
  localparam logic [3:0] KIND_END       = 4'd6;
  localparam logic [3:0] KIND_READ      = 4'd7;
  localparam logic [3:0] KIND_MARK      = 4'd8;

  localparam logic CFG_INSERT_ON  = 1'b0;
  localparam logic CFG_TEXT_COLOR = 1'b1;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] RESET_COLOR = 8'd7;

  localparam int KIND_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;

endpackage

// File: hdl/tcle_cell_ram.sv
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcle_pkg for the cell width.
`timescale 1ns / 1ps

module tcle_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tcle_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [tcle_pkg::CELL_W-1:0] rdata
);

  logic [tcle_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcle_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/text_console_line_editor.sv
// Text console line editor top level; uses tcle_pkg, tcle_cell_ram, assert_macros.svh.
// Flow: a move, a mark or an unused kind goes from EXEC to DONE; a read or a put passes
//   READ or PUT on the way; a newline first walks ROWFIND row by row; a shift runs COPY, DRAIN.
// A scroll adds COPY, DRAIN and BLANK. Throughput: one item at a time; the next is taken as the
//   result appears, the copy engine moving one cell per cycle through the single write port.
// Reset (sync, rst_n low) clears cursor and marks, then a clearing pass writes every
//   cell blank while in_stall is held; config is taken throughout.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_line_editor #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcle_pkg::KIND_W-1:0]  in_kind,
  input  logic [tcle_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcle_pkg::POS_W-1:0]   in_cell_addr,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcle_pkg::CELL_W-1:0]  out_cell_data,
  output logic [tcle_pkg::POS_W-1:0]   out_cursor_pos,
  output logic [tcle_pkg::POS_W-1:0]   out_line_start,
  output logic [tcle_pkg::POS_W-1:0]   out_line_end,
  output logic                         out_scrolled,
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [tcle_pkg::COLOR_W-1:0] cfg_data
);

  // Geometry. AW indexes the store, PW also holds NCELLS itself.
  localparam int NCELLS = COLS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int PW     = $clog2(NCELLS + 1);
  localparam int OW     = tcle_pkg::POS_W;
  localparam int CW     = tcle_pkg::CELL_W;

  localparam logic [PW-1:0] NCELLS_P  = PW'(NCELLS);
  localparam logic [PW-1:0] COLS_P    = PW'(COLS);
  localparam logic [PW-1:0] LASTROW_P = PW'(NCELLS - COLS);
  localparam logic [PW-1:0] SCROLL_N  = PW'(NCELLS - COLS);
  localparam logic [PW:0]   COLS_E    = (PW+1)'(COLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLS);
  localparam logic [AW-1:0] LAST_A    = AW'(NCELLS - 1);
  localparam logic [AW-1:0] LASTROW_A = AW'(NCELLS - COLS);
  localparam logic [CW-1:0] BLANK_RST = {tcle_pkg::RESET_COLOR, tcle_pkg::CH_SPACE};

  // Sequencer and edit state
  tcle_pkg::state_t     state_r, state_nxt;
  tcle_pkg::copy_mode_t mode_r, mode_nxt;
  logic [PW-1:0]        cursor_r, cursor_nxt;
  logic [PW-1:0]        smark_r, smark_nxt;
  logic [PW-1:0]        emark_r, emark_nxt;
  logic [PW-1:0]        emark_inc;
  logic                 insert_on_r, insert_on_nxt;
  logic [7:0]           color_r, color_nxt;

  // Latched command
  logic [tcle_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [tcle_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [OW-1:0]               addr_r, addr_nxt;
  logic                        is_newline;

  // Sweep engine: address walker, remaining count, one pending copy write
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;

  // Result being built and the output register
  logic [CW-1:0] data_r, data_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_data_r, out_data_nxt;
  logic [OW-1:0] out_cur_r, out_cur_nxt;
  logic [OW-1:0] out_start_r, out_start_nxt;
  logic [OW-1:0] out_end_r, out_end_nxt;
  logic          out_scr_r, out_scr_nxt;

  // Store port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  function automatic logic [PW-1:0] drop_row(input logic [PW-1:0] p);
    return (p >= COLS_P) ? p - COLS_P : '0;
  endfunction

  tcle_cell_ram #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall   = (state_r != tcle_pkg::ST_IDLE);
  assign is_newline = (ch_r == tcle_pkg::CH_NEWLINE);
  // Insert always grows the line; overwrite grows it only at the line end.
  assign emark_inc  = (insert_on_r || cursor_r == emark_r) ? emark_r + PW'(1) : emark_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cursor_nxt    = cursor_r;
    smark_nxt     = smark_r;
    emark_nxt     = emark_r;
    insert_on_nxt = insert_on_r;
    color_nxt     = color_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    addr_nxt      = addr_r;
    sweep_nxt     = sweep_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    data_nxt      = data_r;
    scrolled_nxt  = scrolled_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_cur_nxt   = out_cur_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_scr_nxt   = out_scr_r;
    mem_raddr     = sweep_r;

    // Each copy write goes out in the cycle after its read.
    mem_we    = wr_pend_r;
    mem_waddr = wr_addr_r;
    mem_wdata = mem_rdata;

    if (cfg_wr_en) begin
      unique case (cfg_index)
        tcle_pkg::CFG_INSERT_ON:  insert_on_nxt = cfg_data[0];
        tcle_pkg::CFG_TEXT_COLOR: color_nxt     = cfg_data;
      endcase
    end

    unique case (state_r)
      tcle_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = BLANK_RST;
        if (sweep_r == LAST_A) begin
          sweep_nxt = '0;
          state_nxt = tcle_pkg::ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      tcle_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          ch_nxt    = in_char_code;
          addr_nxt  = in_cell_addr;
          state_nxt = tcle_pkg::ST_EXEC;
        end
      end

      tcle_pkg::ST_EXEC: begin
        scrolled_nxt = 1'b0;
        data_nxt     = '0;
        mem_raddr    = AW'(addr_r);
        unique case (kind_r)
          tcle_pkg::KIND_PUT: begin
            if (is_newline) begin
              base_nxt  = '0;
              state_nxt = tcle_pkg::ST_ROWFIND;
            end else if (insert_on_r && emark_r != cursor_r) begin
              // open a gap: move cells cursor..end-1 up by one, top first
              sweep_nxt = AW'(emark_r - PW'(1));
              cnt_nxt   = emark_r - cursor_r;
              mode_nxt  = tcle_pkg::CP_INSERT;
              state_nxt = tcle_pkg::ST_COPY;
            end else begin
              state_nxt = tcle_pkg::ST_PUT;
            end
          end
          tcle_pkg::KIND_BACKSPACE: begin
            if (cursor_r > smark_r) begin
              sweep_nxt  = AW'(cursor_r);
              cnt_nxt    = emark_r - cursor_r + PW'(1);
              mode_nxt   = tcle_pkg::CP_LEFT;
              cursor_nxt = cursor_r - PW'(1);
              emark_nxt  = emark_r - PW'(1);
              state_nxt  = tcle_pkg::ST_COPY;
            end else begin
              state_nxt = tcle_pkg::ST_DONE;
            end
          end
          tcle_pkg::KIND_DELETE: begin
            if (cursor_r < emark_r) begin
              sweep_nxt = AW'(cursor_r + PW'(1));
              cnt_nxt   = emark_r - cursor_r;
              mode_nxt  = tcle_pkg::CP_LEFT;
              emark_nxt = emark_r - PW'(1);
              state_nxt = tcle_pkg::ST_COPY;
            end else begin
              state_nxt = tcle_pkg::ST_DONE;
            end
          end
          tcle_pkg::KIND_LEFT: begin
            if (cursor_r > smark_r) cursor_nxt = cursor_r - PW'(1);
            state_nxt = tcle_pkg::ST_DONE;
          end
          tcle_pkg::KIND_RIGHT: begin
            if (cursor_r < emark_r) cursor_nxt = cursor_r + PW'(1);
            state_nxt = tcle_pkg::ST_DONE;
          end
          tcle_pkg::KIND_HOME: begin
            cursor_nxt = smark_r;
            state_nxt  = tcle_pkg::ST_DONE;
          end
          tcle_pkg::KIND_END: begin
            cursor_nxt = emark_r;
            state_nxt  = tcle_pkg::ST_DONE;
          end
          tcle_pkg::KIND_READ: begin
            state_nxt = tcle_pkg::ST_READ;
          end
          tcle_pkg::KIND_MARK: begin
            smark_nxt = cursor_r;
            emark_nxt = cursor_r;
            state_nxt = tcle_pkg::ST_DONE;
          end
          default: begin
            state_nxt = tcle_pkg::ST_DONE;
          end
        endcase
      end

      // Find the start of the cursor's row, one row per cycle, then move to the next row or scroll.
      tcle_pkg::ST_ROWFIND: begin
        if ({1'b0, cursor_r} >= {1'b0, base_r} + COLS_E) begin
          base_nxt = base_r + COLS_P;
        end else if (base_r >= LASTROW_P) begin
          sweep_nxt = COLS_A;
          cnt_nxt   = SCROLL_N;
          mode_nxt  = tcle_pkg::CP_SCROLL;
          state_nxt = tcle_pkg::ST_COPY;
        end else begin
          cursor_nxt = base_r + COLS_P;
          smark_nxt  = base_r + COLS_P;
          emark_nxt  = base_r + COLS_P;
          state_nxt  = tcle_pkg::ST_DONE;
        end
      end

      tcle_pkg::ST_COPY: begin
        mem_raddr   = sweep_r;
        wr_pend_nxt = 1'b1;
        cnt_nxt     = cnt_r - PW'(1);
        case (mode_r)
          tcle_pkg::CP_SCROLL: begin
            wr_addr_nxt = sweep_r - COLS_A;
            sweep_nxt   = sweep_r + AW'(1);
          end
          tcle_pkg::CP_INSERT: begin
            wr_addr_nxt = sweep_r + AW'(1);
            sweep_nxt   = sweep_r - AW'(1);
          end
          default: begin
            wr_addr_nxt = sweep_r - AW'(1);
            sweep_nxt   = sweep_r + AW'(1);
          end
        endcase
        if (cnt_r == PW'(1)) state_nxt = tcle_pkg::ST_DRAIN;
      end

      // Last copy write goes out this cycle.
      tcle_pkg::ST_DRAIN: begin
        case (mode_r)
          tcle_pkg::CP_SCROLL: begin
            sweep_nxt = LASTROW_A;
            state_nxt = tcle_pkg::ST_BLANK;
          end
          tcle_pkg::CP_INSERT: state_nxt = tcle_pkg::ST_PUT;
          default:             state_nxt = tcle_pkg::ST_DONE;
        endcase
      end

      tcle_pkg::ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(cursor_r);
        mem_wdata  = {color_r, ch_r};
        emark_nxt  = emark_inc;
        cursor_nxt = cursor_r + PW'(1);
        if (emark_inc >= NCELLS_P) begin
          sweep_nxt = COLS_A;
          cnt_nxt   = SCROLL_N;
          mode_nxt  = tcle_pkg::CP_SCROLL;
          state_nxt = tcle_pkg::ST_COPY;
        end else begin
          state_nxt = tcle_pkg::ST_DONE;
        end
      end

      // Blank the last row; then cursor and marks rise a row, or go to its start for a newline.
      tcle_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = {color_r, tcle_pkg::CH_SPACE};
        if (sweep_r == LAST_A) begin
          scrolled_nxt = 1'b1;
          if (kind_r == tcle_pkg::KIND_PUT && is_newline) begin
            cursor_nxt = LASTROW_P;
            smark_nxt  = LASTROW_P;
            emark_nxt  = LASTROW_P;
          end else begin
            cursor_nxt = drop_row(cursor_r);
            smark_nxt  = drop_row(smark_r);
            emark_nxt  = drop_row(emark_r);
          end
          state_nxt = tcle_pkg::ST_DONE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      tcle_pkg::ST_READ: begin
        data_nxt  = (32'(addr_r) < 32'(NCELLS)) ? mem_rdata : '0;
        state_nxt = tcle_pkg::ST_DONE;
      end

      tcle_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_cur_nxt   = OW'(cursor_r);
          out_start_nxt = OW'(smark_r);
          out_end_nxt   = OW'(emark_r);
          out_scr_nxt   = scrolled_r;
          state_nxt     = tcle_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcle_pkg::ST_CLEAR;
      sweep_r     <= '0;
      cursor_r    <= '0;
      smark_r     <= '0;
      emark_r     <= '0;
      insert_on_r <= 1'b0;
      color_r     <= tcle_pkg::RESET_COLOR;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cursor_r    <= cursor_nxt;
      smark_r     <= smark_nxt;
      emark_r     <= emark_nxt;
      insert_on_r <= insert_on_nxt;
      color_r     <= color_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    kind_r      <= kind_nxt;
    ch_r        <= ch_nxt;
    addr_r      <= addr_nxt;
    cnt_r       <= cnt_nxt;
    base_r      <= base_nxt;
    wr_addr_r   <= wr_addr_nxt;
    data_r      <= data_nxt;
    scrolled_r  <= scrolled_nxt;
    out_data_r  <= out_data_nxt;
    out_cur_r   <= out_cur_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_cursor_pos = out_cur_r;
  assign out_line_start = out_start_r;
  assign out_line_end   = out_end_r;
  assign out_scrolled   = out_scr_r;

  // Line marks stay ordered and inside the screen between items.
  `TCLE_ASSERT_IMPL(a_marks_ordered, state_r == tcle_pkg::ST_IDLE, smark_r <= cursor_r && cursor_r <= emark_r && emark_r < NCELLS_P, "line marks out of order")
  // No copy write may still be in flight once the block takes a new item.
  `TCLE_ASSERT_IMPL(a_idle_no_pending, state_r == tcle_pkg::ST_IDLE, !wr_pend_r, "copy write pending while idle")
  // A finished result waits while the output register is held.
  `TCLE_ASSERT_NEXT(a_done_waits, state_r == tcle_pkg::ST_DONE && out_valid_r && out_stall, state_r == tcle_pkg::ST_DONE, "result dropped while output stalled")

endmodule
